/* hw/rtl/ewbb_pkg.sv */
// Shared types and constants for the equal-width bucket boundary block.
// Used by the top level, the port checker and the testbench.
package ewbb_pkg;

   // Fixed field widths of the result channel
   localparam int BUCKET_BITS = 6;
   localparam int COUNT_BITS  = 32;
   localparam int NB_BITS     = 7;
   localparam int MAX_BUCKETS = 64;

   // Result tdata: bucket_number, end_position, padded to whole bytes
   localparam int RSP_DATA_W  = ((BUCKET_BITS + COUNT_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - BUCKET_BITS - COUNT_BITS;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_MIN_START   = 2'd0;
   localparam csr_index_type CSR_MAX_START   = 2'd1;
   localparam csr_index_type CSR_NUM_BUCKETS = 2'd2;

   typedef logic [BUCKET_BITS-1:0] bucket_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [NB_BITS-1:0]     nb_type;

   // Bucket count clamped to 1..MAX_BUCKETS
   function automatic nb_type eff_buckets(input nb_type raw);
      nb_type n;
      n = raw;
      if (raw == '0) begin
         n = nb_type'(1);
      end else if (raw > nb_type'(MAX_BUCKETS)) begin
         n = nb_type'(MAX_BUCKETS);
      end
      return n;
   endfunction

endpackage

/* hw/rtl/ewbb_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by the width and the bucket computation.
module ewbb_div #(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_in,
   input  logic [TIME_BITS-1:0] dividend_in,
   input  logic [TIME_BITS-1:0] divisor_in,
   output logic                 done_out,
   output logic [TIME_BITS-1:0] quotient_out,
   output logic [TIME_BITS-1:0] remainder_out
);

   localparam int CW = $clog2(TIME_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [TIME_BITS-1:0] dsr_ff, dsr_in;
   logic [TIME_BITS:0]   shifted;
   logic [TIME_BITS:0]   trial;
   logic                 fits;

   // One shift-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_BITS-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start_in) begin
         busy_in = 1'b1;
         cnt_in  = CW'(TIME_BITS);
         rem_in  = '0;
         quo_in  = dividend_in;
         dsr_in  = divisor_in;
      end else if (busy_ff) begin
         rem_in = fits ? trial[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
         quo_in = {quo_ff[TIME_BITS-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done_out      = done_ff;
   assign quotient_out  = quo_ff;
   assign remainder_out = rem_ff;

endmodule

/* hw/rtl/equal_width_bucket_boundaries_top.sv */
// Equal-width bucket boundary builder: sequencer, registers, result stage.
// Depends on ewbb_pkg and ewbb_div.
//
// Records enter one at a time, sorted by start time. Each record needs a
// bucket division and then one result transfer per reported bucket; the
// first record of a run first needs a division to fix the bucket width. Both
// come from the one shared radix-2 divider, which produces one quotient bit
// per cycle and is used for the width division and for each record's bucket
// division. The result register lets the block take the next record while the
// last result of the previous one is still waiting. Registers must be written
// only while idle; the block itself does not enforce this.
module equal_width_bucket_boundaries_top
   import ewbb_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input records
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((TIME_BITS+7)/8)*8-1:0]        req_tdata,  // start_time
   input  logic                                  req_tlast,  // final_record
   // Bucket boundaries
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [RSP_DATA_W-1:0]                 rsp_tdata,  // bucket_number, end_position
   output logic                                  rsp_tlast,  // last_of_run
   // Configuration writes
   input  logic                                  csr_we,
   input  logic [CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [TIME_BITS-1:0]                  csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WIDTH  = 3'd1;
   localparam logic [2:0] S_TSTART = 3'd2;
   localparam logic [2:0] S_TARGET = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   // Configuration registers
   logic [TIME_BITS-1:0] min_ff, max_ff;
   nb_type               nb_cfg_ff;

   // Sequencer and run state
   logic [2:0]           state_ff, state_in;
   bucket_type           cur_ff, cur_in;
   count_type            count_ff, count_in;
   logic [TIME_BITS-1:0] width_ff, width_in;
   bucket_type           target_ff, target_in;
   logic [TIME_BITS-1:0] diff_ff, diff_in;
   logic                 final_ff, final_in;
   nb_type               nb_ff, nb_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   bucket_type           rsp_bucket_ff, rsp_bucket_in;
   count_type            rsp_pos_ff, rsp_pos_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Divider connection
   logic                 div_start;
   logic [TIME_BITS-1:0] div_dividend, div_divisor;
   logic                 div_done;
   logic [TIME_BITS-1:0] div_quo, div_rem;

   // Combinational helpers
   nb_type               nb_now;
   logic [TIME_BITS-1:0] start_time;
   logic [TIME_BITS-1:0] diff_now;
   logic [TIME_BITS-1:0] span;
   logic                 req_fire;
   logic                 out_free;
   logic                 run_start;
   logic [TIME_BITS:0]   q_ceil;
   nb_type               top_bucket;
   bucket_type           cur_next;

   ewbb_div #(.TIME_BITS(TIME_BITS)) u_div (
      .clock         (clock),
      .reset         (reset),
      .start_in      (div_start),
      .dividend_in   (div_dividend),
      .divisor_in    (div_divisor),
      .done_out      (div_done),
      .quotient_out  (div_quo),
      .remainder_out (div_rem)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= '0;
         max_ff    <= '0;
         nb_cfg_ff <= nb_type'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_START:   min_ff    <= csr_wdata;
            CSR_MAX_START:   max_ff    <= csr_wdata;
            CSR_NUM_BUCKETS: nb_cfg_ff <= csr_wdata[NB_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Record decode and divider operand selection
   always_comb begin
      nb_now     = eff_buckets(nb_cfg_ff);
      start_time = req_tdata[TIME_BITS-1:0];
      diff_now   = (start_time >= min_ff) ? start_time - min_ff : '0;
      span       = (max_ff <= min_ff) ? TIME_BITS'(1) : max_ff - min_ff;
      req_fire   = req_tvalid && req_tready;
      out_free   = !rsp_valid_ff || rsp_tready;
      run_start  = count_ff == '0;
      q_ceil     = {1'b0, div_quo} + (TIME_BITS+1)'(div_rem != '0);
      top_bucket = nb_ff - nb_type'(1);
      cur_next   = cur_ff + bucket_type'(1);

      div_start    = (state_ff == S_IDLE && req_fire) || state_ff == S_TSTART;
      div_dividend = diff_ff;
      div_divisor  = width_ff;
      if (state_ff == S_IDLE) begin
         div_dividend = run_start ? span : diff_now;
         div_divisor  = run_start ? {{(TIME_BITS-NB_BITS){1'b0}}, nb_now} : width_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      width_in      = width_ff;
      target_in     = target_ff;
      diff_in       = diff_ff;
      final_in      = final_ff;
      nb_in         = nb_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               diff_in  = diff_now;
               final_in = req_tlast;
               nb_in    = nb_now;
               state_in = run_start ? S_WIDTH : S_TARGET;
            end
         end
         S_WIDTH: begin
            if (div_done) begin
               width_in = q_ceil[TIME_BITS-1:0];
               state_in = S_TSTART;
            end
         end
         S_TSTART: begin
            state_in = S_TARGET;
         end
         S_TARGET: begin
            if (div_done) begin
               // clamp to the top bucket
               if (q_ceil > (TIME_BITS+1)'(top_bucket)) begin
                  target_in = top_bucket[BUCKET_BITS-1:0];
               end else begin
                  target_in = q_ceil[BUCKET_BITS-1:0];
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // close every bucket the running bucket passes
            if (cur_ff < target_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_bucket_in = cur_ff;
                  rsp_pos_in    = count_ff;
                  rsp_last_in   = (cur_next == target_ff) && !final_ff;
                  cur_in        = cur_next;
               end
            end else begin
               count_in = count_ff + count_type'(1);
               state_in = final_ff ? S_FINAL : S_IDLE;
            end
         end
         S_FINAL: begin
            // close the remaining buckets with the record count
            if ({1'b0, cur_ff} < nb_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_bucket_in = cur_ff;
                  rsp_pos_in    = count_ff;
                  rsp_last_in   = ({1'b0, cur_ff} + nb_type'(1)) == nb_ff;
                  cur_in        = cur_next;
                  if (rsp_last_in) begin
                     cur_in   = '0;
                     count_in = '0;
                     width_in = '0;
                     state_in = S_IDLE;
                  end
               end
            end else begin
               cur_in   = '0;
               count_in = '0;
               width_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         count_ff     <= '0;
         width_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Per-record payload
   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      diff_ff       <= diff_in;
      final_ff      <= final_in;
      nb_ff         <= nb_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_pos_ff, rsp_bucket_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/ewbb_check.sv */
// Port-level checker for the equal-width bucket boundary block.
// Depends on ewbb_pkg; bound to the top level at the end of this file.
module ewbb_check
   import ewbb_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [((TIME_BITS+7)/8)*8-1:0] req_tdata,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [RSP_DATA_W-1:0]          rsp_tdata,
   input logic                           rsp_tlast
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Stalled record holds
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("record changed while stalled");

   // Out of reset: idle, nothing to report
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready && !rsp_tvalid)
      else $error("bad state after reset");

   // A record transfer makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("record taken while busy");

   // After a non-final result the block stays busy unless the last one is waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready || rsp_tvalid)
      else $error("record taken before its results were done");

endmodule

bind equal_width_bucket_boundaries_top ewbb_check #(.TIME_BITS(TIME_BITS)) u_ewbb_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* sim/equal_width_bucket_boundaries_top_test.sv */
// Self-checking testbench for equal_width_bucket_boundaries_top.
// Predicts bucket end boundaries in the testbench itself and checks every rsp transfer.
// Depends on ewbb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module equal_width_bucket_boundaries_top_test;
   import ewbb_pkg::*;

   localparam int  TIME_BITS      = 32;
   localparam time CLOCK_PERIOD   = 12ns;
   localparam int  RESET_CYCLES   = 8;
   localparam int  SETTLE_CYCLES  = 120;   // first record of a run needs two divisions
   localparam int  WATCHDOG_LIMIT = 4000;
   localparam int  RANDOM_RECORDS = 80;

   typedef struct packed {
      logic [31:0] start_time;
      logic        final_record;
   } record_type;

   typedef struct packed {
      bucket_type bucket_number;
      count_type  end_position;
      logic       last_of_run;
   } boundary_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [31:0]               req_tdata = '0;   // start_time
   logic                      req_tlast = 1'b0; // final_record
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;        // bucket_number, end_position, pad
   logic                      rsp_tlast;        // last_of_run
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [TIME_BITS-1:0]      csr_wdata = '0;

   // Register copies and run state of the boundary predictor
   logic [31:0] cfg_min_start   = '0;
   logic [31:0] cfg_max_start   = '0;
   logic [6:0]  cfg_num_buckets = 7'd1;
   logic [63:0] run_bucket = '0;
   logic [31:0] run_count  = '0;
   logic [32:0] run_width  = '0;

   record_type   pending_records[$];
   boundary_type expected_boundaries[$];
   int           mismatch_count = 0;
   int           records_queued = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;
   bit           idle_on = 1'b1;

   equal_width_bucket_boundaries_top #(.TIME_BITS(TIME_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Boundaries that one accepted record closes
   function automatic void predict_boundaries(input record_type rec);
      logic [63:0]  nb;
      logic [63:0]  span;
      logic [63:0]  diff;
      logic [63:0]  width;
      logic [63:0]  target;
      logic [63:0]  bkt;
      int           produced;
      boundary_type b;
      produced = 0;
      nb = 64'(cfg_num_buckets);
      if (nb == 64'd0) begin
         nb = 64'd1;
      end else if (nb > 64'(MAX_BUCKETS)) begin
         nb = 64'(MAX_BUCKETS);
      end
      // width is fixed on the first record of a run
      if (run_count == '0) begin
         span = (cfg_max_start <= cfg_min_start) ? 64'd1 :
                64'(cfg_max_start) - 64'(cfg_min_start);
         run_width = 33'((span + nb - 64'd1) / nb);
         if (run_width == '0) begin
            run_width = 33'd1;
         end
      end
      diff = (rec.start_time >= cfg_min_start) ?
             64'(rec.start_time) - 64'(cfg_min_start) : 64'd0;
      width = (run_width == '0) ? 64'd1 : 64'(run_width);
      target = diff / width + (((diff % width) != 64'd0) ? 64'd1 : 64'd0);
      if (target > nb - 64'd1) begin
         target = nb - 64'd1;
      end
      while (run_bucket < target) begin
         b.bucket_number = run_bucket[5:0];
         b.end_position  = run_count;
         b.last_of_run   = 1'b0;
         expected_boundaries.push_back(b);
         produced++;
         run_bucket++;
      end
      run_count = run_count + 32'd1;
      // close what is left of the run, then start over
      if (rec.final_record) begin
         for (bkt = run_bucket; bkt < nb; bkt++) begin
            b.bucket_number = bkt[5:0];
            b.end_position  = run_count;
            b.last_of_run   = 1'b0;
            expected_boundaries.push_back(b);
            produced++;
         end
         run_bucket = '0;
         run_count  = '0;
         run_width  = '0;
      end
      if (produced > 0) begin
         expected_boundaries[expected_boundaries.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   // Record driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_boundaries('{start_time: req_tdata, final_record: req_tlast});
            if (idle_on && $urandom_range(0, 3) == 0) begin
               gap_left = int'($urandom_range(1, 13));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_records.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_records[0].start_time;
               req_tlast  <= pending_records[0].final_record;
               void'(pending_records.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Boundary monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_boundaries.size() == 0) begin
               $error("rsp transfer with no boundary expected: bucket %0d end %0d",
                      rsp_tdata[5:0], rsp_tdata[37:6]);
               mismatch_count++;
            end else begin
               if (rsp_tdata[5:0] !== expected_boundaries[0].bucket_number) begin
                  $error("bucket_number: expected %0d, actual %0d",
                         expected_boundaries[0].bucket_number, rsp_tdata[5:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[37:6] !== expected_boundaries[0].end_position) begin
                  $error("end_position: expected %0d, actual %0d",
                         expected_boundaries[0].end_position, rsp_tdata[37:6]);
                  mismatch_count++;
               end
               if (rsp_tlast !== expected_boundaries[0].last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         expected_boundaries[0].last_of_run, rsp_tlast);
                  mismatch_count++;
               end
               void'(expected_boundaries.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            stall_left = int'($urandom_range(1, 13)) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MIN_START:   cfg_min_start = value;
         CSR_MAX_START:   cfg_max_start = value;
         CSR_NUM_BUCKETS: cfg_num_buckets = value[6:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_buckets(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [31:0] nb);
      write_csr(CSR_MIN_START, lo);
      write_csr(CSR_MAX_START, hi);
      write_csr(CSR_NUM_BUCKETS, nb);
   endtask

   task automatic queue_record(input logic [31:0] start, input logic fin);
      pending_records.push_back('{start_time: start, final_record: fin});
      records_queued++;
   endtask

   // Hold off until every record is in and every boundary is out, then let
   // a record with no boundaries finish its divisions.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_records.size() != 0 || req_tvalid ||
                 expected_boundaries.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One sorted run from about lo with some out-of-order and stray starts
   task automatic queue_run(input int len, input logic [63:0] lo, input logic [63:0] span);
      logic [63:0] t;
      logic [63:0] step;
      logic [63:0] back;
      int          k;
      t = lo;
      if ($urandom_range(0, 7) == 0) begin
         t = (lo > 64'd100) ? lo - 64'($urandom_range(1, 100)) : 64'd0;
      end
      step = (span * 64'd2) / 64'(len) + 64'd1;
      if (step > 64'hFFFF_FFFF) begin
         step = 64'hFFFF_FFFF;
      end
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               back = 64'($urandom_range(0, step[31:0]));
               queue_record((t > back) ? 32'(t - back) : 32'd0, k == len - 1);
            end
            2: begin
               queue_record($urandom, k == len - 1);
            end
            default: begin
               t = t + 64'($urandom_range(0, step[31:0]));
               if (t > 64'hFFFF_FFFF) begin
                  t = 64'hFFFF_FFFF;
               end
               queue_record(t[31:0], k == len - 1);
            end
         endcase
      end
   endtask

   task automatic random_phase();
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] nb;
      logic [63:0] span;
      int          runs;
      case ($urandom_range(0, 5))
         0: begin
            lo = '0;
            hi = 32'hFFFF_FFFF;
         end
         1: begin
            lo = $urandom;
            hi = lo;
         end
         2: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = $urandom_range(0, 32'h7FFF_FFFF);
            hi = lo + $urandom_range(0, 32'h0000_FFFF);
         end
      endcase
      case ($urandom_range(0, 7))
         0:       nb = 32'd1;
         1:       nb = 32'd64;
         2:       nb = 32'd0;
         3:       nb = $urandom_range(65, 127);
         default: nb = $urandom_range(1, 16);
      endcase
      set_buckets(lo, hi, nb);
      span = (hi > lo) ? 64'(hi) - 64'(lo) : 64'd1;
      span = span + span / 64'd4 + 64'd2;   // reach past max now and then
      for (runs = int'($urandom_range(1, 3)); runs > 0; runs--) begin
         queue_run(int'($urandom_range(1, 8)), 64'(lo), span);
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Width 10 over 64 buckets: below min, exact hit, round up, out of order,
      // clamp to the top bucket, all-ones start
      set_buckets(32'd1000, 32'd1640, 32'd64);
      queue_record(32'd0, 1'b0);
      queue_record(32'd1000, 1'b0);
      queue_record(32'd1001, 1'b0);
      queue_record(32'd1025, 1'b0);
      queue_record(32'd1010, 1'b0);
      queue_record(32'd5000, 1'b0);
      queue_record(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // Max below min with a zero bucket count
      set_buckets(32'hFFFF_FFF0, 32'd5, 32'd0);
      queue_record(32'd0, 1'b0);
      queue_record(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // Bucket count above the limit, zero span
      set_buckets(32'd0, 32'd0, 32'd127);
      queue_record(32'd0, 1'b0);
      queue_record(32'd1, 1'b0);
      queue_record(32'd63, 1'b0);
      queue_record(32'd2, 1'b1);
      wait_idle();

      // Full span, then bucket count lowered and min raised inside the run
      set_buckets(32'd0, 32'hFFFF_FFFF, 32'd64);
      queue_record(32'h8000_0000, 1'b0);
      wait_idle();
      write_csr(CSR_NUM_BUCKETS, 32'd4);
      write_csr(CSR_MIN_START, 32'h1000_0000);
      queue_record(32'h9000_0000, 1'b0);
      queue_record(32'hA000_0000, 1'b1);
      queue_record(32'h0000_0001, 1'b1);
      wait_idle();

      // Random phases; idling switched off in some and in the last one
      records_queued = 0;
      while (records_queued < RANDOM_RECORDS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         random_phase();
      end
      idle_on = 1'b0;
      random_phase();

      if (mismatch_count == 0 && expected_boundaries.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
